[src/assert_macros.svh]
// Assertion helpers for the execute block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mse_pkg.sv]
`default_nettype none
package mse_pkg;
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_ADDI = 4'd4,
        OP_SUBI = 4'd5,
        OP_LW   = 4'd6,
        OP_SW   = 4'd7,
        OP_BEQ  = 4'd8,
        OP_J    = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_DIV0  = 2'd1,
        FAULT_RANGE = 2'd2
    } t_fault;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_DIVFIX,
        ST_MEM,
        ST_LOAD,
        ST_DONE
    } t_state;

    localparam logic [4:0] SP_REG = 5'd29;
endpackage
`default_nettype wire

[src/mips_subset_execute.sv]
`default_nettype none
`include "assert_macros.svh"
// Executes one pre-decoded instruction per request against a 32-entry register file,
// a stack word memory and a program counter. Add, sub, addi, subi, beq, j, faults and
// lw/sw with a base other than $sp finish in the execute state after the register
// read; sw finishes in a memory state and lw after a further load state (registered
// stack memory port); mul and div go through one shared 32-step shift/add-subtract
// unit and a fixup state. One request is in flight at a time: the next request is
// accepted only when no result is pending or the pending result is taken at the same
// edge. After reset, a clearing pass writes zero to every stack word before the first
// request.
module mips_subset_execute #(
    parameter int STACK_WORDS      = 1024,
    parameter int STACK_BASE_INDEX = 1000,
    parameter int PROGRAM_WORDS    = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire         [3:0]  i_mode,
    input  wire         [4:0]  i_dest_reg,
    input  wire         [4:0]  i_src_reg_a,
    input  wire         [4:0]  i_src_reg_b,
    input  wire signed  [15:0] i_immediate,
    input  wire         [9:0]  i_target_index,
    output logic               o_valid,
    input  wire                i_ready,
    output logic        [9:0]  o_next_pc,
    output logic               o_wrote_register,
    output logic        [4:0]  o_written_index,
    output logic signed [31:0] o_written_value,
    output logic        [1:0]  o_fault
);
    localparam int SAW = (STACK_WORDS > 2) ? $clog2(STACK_WORDS) : 1;
    localparam int PCW = (PROGRAM_WORDS > 2) ? $clog2(PROGRAM_WORDS) : 1;
    localparam int PSH = 27;
    localparam longint unsigned PRCP =
        ((64'd1 << PSH) + 64'(PROGRAM_WORDS) - 64'd1) / 64'(PROGRAM_WORDS);

    mse_pkg::t_state r_state, n_state;

    logic [31:0] r_rf [32];
    logic [31:0] r_mem [STACK_WORDS];
    logic [31:0] r_memq;

    logic [3:0]  r_mode;
    logic [4:0]  r_rd, r_ra, r_rb;
    logic [31:0] r_imm;
    logic [9:0]  r_tgt;
    logic [31:0] r_va, r_vb, r_vd;
    logic [PCW-1:0] r_pc;
    logic [SAW:0] r_clr;
    logic [SAW-1:0] r_addr;

    logic [63:0] r_acc;
    logic [31:0] r_dv;
    logic [5:0]  r_cnt;
    logic        r_negq;

    logic        r_ov;
    logic [9:0]  r_opc;
    logic        r_owr;
    logic [4:0]  r_oidx;
    logic [31:0] r_oval;
    logic [1:0]  r_oflt;

    logic        in_acc, out_acc;
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = (r_state == mse_pkg::ST_IDLE) && (!r_ov || i_ready);
    assign o_valid = r_ov;
    assign o_next_pc        = r_opc;
    assign o_wrote_register = r_owr;
    assign o_written_index  = r_oidx;
    assign o_written_value  = r_oval;
    assign o_fault          = r_oflt;

    // Stack index: sp/4 + imm/4 + base, truncating toward zero.
    logic signed [33:0] idx;
    logic signed [31:0] spq;
    logic signed [31:0] imq;
    always_comb begin
        spq = $signed(r_va) >>> 2;
        if (r_va[31] && (r_va[1:0] != 2'b00)) spq = spq + 32'sd1;
        imq = $signed(r_imm) >>> 2;
        if (r_imm[31] && (r_imm[1:0] != 2'b00)) imq = imq + 32'sd1;
        idx = 34'(spq) + 34'(imq) + 34'(STACK_BASE_INDEX);
    end
    logic idx_bad;
    assign idx_bad = idx[33] || (idx >= 34'(STACK_WORDS));

    // Wrap the target by reciprocal multiplication.
    logic [36:0] tgt_prod;
    logic [9:0]  tgt_q;
    logic [9:0]  tgt_r;
    assign tgt_prod = 37'(r_tgt) * 37'(PRCP);
    assign tgt_q    = tgt_prod[36:PSH];
    assign tgt_r    = r_tgt - 10'(32'(tgt_q) * 32'(PROGRAM_WORDS));

    logic [PCW-1:0] pc_inc, pc_tgt;
    assign pc_inc = (32'(r_pc) + 32'd1 >= 32'(PROGRAM_WORDS)) ? '0 : r_pc + PCW'(1);
    assign pc_tgt = PCW'(tgt_r);

    logic [31:0] abs_a, abs_b;
    assign abs_a = r_va[31] ? (~r_va + 32'd1) : r_va;
    assign abs_b = r_vb[31] ? (~r_vb + 32'd1) : r_vb;

    logic [32:0] dsub;
    assign dsub = {r_acc[63:31]} - {1'b0, r_dv};

    // Result writeback controls.
    logic        fin;
    logic        fin_wr;
    logic [31:0] fin_val;
    logic [1:0]  fin_flt;
    logic [PCW-1:0] fin_pc;
    logic        mem_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mse_pkg::ST_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        fin = 1'b0; fin_wr = 1'b0; fin_val = '0; fin_flt = mse_pkg::FAULT_NONE;
        fin_pc = pc_inc; mem_wr = 1'b0;
        unique case (r_state)
            mse_pkg::ST_CLEAR: if (r_clr == (SAW+1)'(STACK_WORDS - 1)) n_state = mse_pkg::ST_IDLE;
            mse_pkg::ST_IDLE:  if (in_acc) n_state = mse_pkg::ST_READ;
            mse_pkg::ST_READ:  n_state = mse_pkg::ST_EXEC;
            mse_pkg::ST_EXEC: begin
                unique case (r_mode) inside
                    mse_pkg::OP_ADD:  begin fin = 1'b1; fin_wr = 1'b1; fin_val = r_va + r_vb; end
                    mse_pkg::OP_SUB:  begin fin = 1'b1; fin_wr = 1'b1; fin_val = r_va - r_vb; end
                    mse_pkg::OP_ADDI: begin fin = 1'b1; fin_wr = 1'b1; fin_val = r_va + r_imm; end
                    mse_pkg::OP_SUBI: begin fin = 1'b1; fin_wr = 1'b1; fin_val = r_va - r_imm; end
                    mse_pkg::OP_MUL:  n_state = mse_pkg::ST_DIV;
                    mse_pkg::OP_DIV: begin
                        if (r_vb == '0) begin
                            fin = 1'b1; fin_flt = mse_pkg::FAULT_DIV0; fin_pc = r_pc;
                        end else n_state = mse_pkg::ST_DIV;
                    end
                    mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                        if (r_ra != mse_pkg::SP_REG) fin = 1'b1;
                        else if (idx_bad) begin
                            fin = 1'b1; fin_flt = mse_pkg::FAULT_RANGE; fin_pc = r_pc;
                        end else n_state = mse_pkg::ST_MEM;
                    end
                    mse_pkg::OP_BEQ: begin
                        fin = 1'b1; if (r_va == r_vb) fin_pc = pc_tgt;
                    end
                    mse_pkg::OP_J: begin fin = 1'b1; fin_pc = pc_tgt; end
                    default: fin = 1'b1;
                endcase
            end
            mse_pkg::ST_DIV: if (r_cnt == 6'd31) n_state = mse_pkg::ST_DIVFIX;
            mse_pkg::ST_DIVFIX: begin
                fin = 1'b1; fin_wr = 1'b1;
                if (r_mode == mse_pkg::OP_MUL) fin_val = r_acc[31:0];
                else fin_val = r_negq ? (~r_acc[31:0] + 32'd1) : r_acc[31:0];
            end
            mse_pkg::ST_MEM: begin
                if (r_mode == mse_pkg::OP_SW) begin mem_wr = 1'b1; fin = 1'b1; end
                else n_state = mse_pkg::ST_LOAD;
            end
            mse_pkg::ST_LOAD: begin fin = 1'b1; fin_wr = 1'b1; fin_val = r_memq; end
            mse_pkg::ST_DONE:  n_state = mse_pkg::ST_IDLE;
            default: n_state = mse_pkg::ST_IDLE;
        endcase
        if (fin) n_state = mse_pkg::ST_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_pc  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (r_state == mse_pkg::ST_CLEAR) r_clr <= r_clr + (SAW+1)'(1);
            if (out_acc) r_ov <= 1'b0;
            if (fin) begin
                r_ov <= 1'b1;
                r_pc <= fin_pc;
            end
        end
    end

    // Register file: cleared at reset, one write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_rf[k] <= '0;
        end else if (fin && fin_wr) begin
            r_rf[r_rd] <= fin_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mse_pkg::ST_CLEAR) r_mem[r_clr[SAW-1:0]] <= '0;
        else if (mem_wr) r_mem[r_addr] <= r_vd;
        r_memq <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode; r_rd <= i_dest_reg; r_ra <= i_src_reg_a; r_rb <= i_src_reg_b;
            r_imm  <= {{16{i_immediate[15]}}, i_immediate};
            r_tgt  <= i_target_index;
        end
        if (r_state == mse_pkg::ST_READ) begin
            r_va <= r_rf[r_ra]; r_vb <= r_rf[r_rb]; r_vd <= r_rf[r_rd];
        end
        if (r_state == mse_pkg::ST_EXEC) begin
            r_addr <= idx[SAW-1:0];
            r_cnt  <= '0;
            r_negq <= r_va[31] ^ r_vb[31];
            if (r_mode == mse_pkg::OP_MUL) begin
                r_acc <= {32'd0, r_vb};
                r_dv  <= r_va;
            end else begin
                r_acc <= {32'd0, abs_a};
                r_dv  <= abs_b;
            end
        end
        if (r_state == mse_pkg::ST_DIV) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_mode == mse_pkg::OP_MUL) begin
                // Shift-add: high half accumulates; low half starts as multiplier, ends as product low word.
                if (r_acc[0]) r_acc <= {1'b0, r_acc[63:32] + r_dv, r_acc[31:1]} >> 0;
                else          r_acc <= {1'b0, r_acc[63:1]};
            end else begin
                if (!dsub[32]) r_acc <= {dsub[31:0], r_acc[30:0], 1'b1};
                else           r_acc <= {r_acc[62:0], 1'b0};
            end
        end
        if (fin) begin
            r_opc  <= 10'(fin_pc);
            r_owr  <= fin_wr;
            r_oidx <= fin_wr ? r_rd : 5'd0;
            r_oval <= fin_wr ? fin_val : 32'd0;
            r_oflt <= fin_flt;
        end
    end

    `CHK_IMPLY(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == mse_pkg::ST_IDLE, "ready outside idle")
    `CHK_NEXT(a_fin_valid, i_clk, i_rst_n, fin, o_valid, "result not presented")
    `CHK_IMPLY(a_fault_nowr, i_clk, i_rst_n, o_valid && (o_fault != mse_pkg::FAULT_NONE), !o_wrote_register, "fault with write")
endmodule
`default_nettype wire

[dv/mse_checker.sv]
module mse_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_req_valid,
    input  wire               i_req_ready,
    input  wire        [3:0]  i_mode,
    input  wire        [4:0]  i_dest_reg,
    input  wire        [4:0]  i_src_reg_a,
    input  wire        [4:0]  i_src_reg_b,
    input  wire signed [15:0] i_immediate,
    input  wire        [9:0]  i_target_index,
    input  wire               i_rsp_valid,
    input  wire               i_rsp_ready,
    input  wire        [9:0]  i_next_pc,
    input  wire               i_wrote_register,
    input  wire        [4:0]  i_written_index,
    input  wire        [31:0] i_written_value,
    input  wire        [1:0]  i_fault,
    output int                o_errors,
    output int                o_pending
);
    localparam int STACK_WORDS      = 1024;
    localparam int STACK_BASE_INDEX = 1000;
    localparam int PROGRAM_WORDS    = 1024;

    typedef struct packed {
        logic [9:0]  next_pc;
        logic        wrote;
        logic [4:0]  windex;
        logic [31:0] wvalue;
        logic [1:0]  fault;
    } t_outcome;

    logic [31:0] regs [32];
    logic [31:0] stack_mem [STACK_WORDS];
    logic [9:0]  pc;
    t_outcome    outcome_q [$];

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic t_outcome execute(logic [3:0] mode, logic [4:0] rd, logic [4:0] ra,
                                         logic [4:0] rb, logic [15:0] imm,
                                         logic [9:0] tgt);
        t_outcome    o;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] imm32;
        logic [9:0]  nxt;
        logic        wr;
        logic [31:0] wval;
        logic [1:0]  flt;
        longint      idx;
        longint      q;
        va    = regs[ra];
        vb    = regs[rb];
        imm32 = {{16{imm[15]}}, imm};
        nxt   = 10'((int'(pc) + 1) % PROGRAM_WORDS);
        wr    = 1'b0;
        wval  = '0;
        flt   = mse_pkg::FAULT_NONE;
        case (mode) inside
            mse_pkg::OP_ADD:  begin wr = 1'b1; wval = va + vb; end
            mse_pkg::OP_SUB:  begin wr = 1'b1; wval = va - vb; end
            mse_pkg::OP_MUL:  begin wr = 1'b1; wval = va * vb; end
            mse_pkg::OP_DIV: begin
                if (vb == 0) begin
                    flt = mse_pkg::FAULT_DIV0;
                end else begin
                    q = sx32(va) / sx32(vb);
                    wr = 1'b1;
                    wval = q[31:0];
                end
            end
            mse_pkg::OP_ADDI: begin wr = 1'b1; wval = va + imm32; end
            mse_pkg::OP_SUBI: begin wr = 1'b1; wval = va - imm32; end
            mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                if (ra == mse_pkg::SP_REG) begin
                    idx = sx32(va) / 4 + sx32(imm32) / 4 + STACK_BASE_INDEX;
                    if (idx < 0 || idx >= STACK_WORDS) begin
                        flt = mse_pkg::FAULT_RANGE;
                    end else if (mode == mse_pkg::OP_LW) begin
                        wr = 1'b1;
                        wval = stack_mem[idx];
                    end else begin
                        stack_mem[idx] = regs[rd];
                    end
                end
            end
            mse_pkg::OP_BEQ:  if (va == vb) nxt = 10'(int'(tgt) % PROGRAM_WORDS);
            mse_pkg::OP_J:    nxt = 10'(int'(tgt) % PROGRAM_WORDS);
            default: ;
        endcase
        if (flt != mse_pkg::FAULT_NONE) nxt = pc;
        if (wr) regs[rd] = wval;
        pc = nxt;
        o.next_pc = nxt;
        o.wrote   = wr;
        o.windex  = wr ? rd : 5'd0;
        o.wvalue  = wr ? wval : 32'd0;
        o.fault   = flt;
        return o;
    endfunction

    initial begin
        o_errors = 0;
        foreach (regs[i]) regs[i] = '0;
        foreach (stack_mem[i]) stack_mem[i] = '0;
        pc = '0;
    end

    assign o_pending = outcome_q.size();

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                outcome_q.push_back(execute(i_mode, i_dest_reg, i_src_reg_a, i_src_reg_b,
                                            i_immediate, i_target_index));
            if (i_rsp_valid && i_rsp_ready) begin
                got = {i_next_pc, i_wrote_register, i_written_index, i_written_value,
                       i_fault};
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch exp pc=%0d wr=%0d idx=%0d val=%h fault=%0d",
                                 $time, want.next_pc, want.wrote, want.windex, want.wvalue,
                                 want.fault);
                        $display("%0t:          act pc=%0d wr=%0d idx=%0d val=%h fault=%0d",
                                 $time, got.next_pc, got.wrote, got.windex, got.wvalue,
                                 got.fault);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[dv/tb_mips_subset_execute.sv]
module tb_mips_subset_execute;
    localparam int LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic        [3:0]  mode = '0;
    logic        [4:0]  dest_reg = '0;
    logic        [4:0]  src_a = '0;
    logic        [4:0]  src_b = '0;
    logic signed [15:0] imm = '0;
    logic        [9:0]  target = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic        [9:0]  next_pc;
    logic               wrote_register;
    logic        [4:0]  written_index;
    logic signed [31:0] written_value;
    logic        [1:0]  fault;
    int                 errors;
    int                 pending;
    int                 cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_off = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mips_subset_execute u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .o_ready(req_ready),
        .i_mode(mode), .i_dest_reg(dest_reg), .i_src_reg_a(src_a), .i_src_reg_b(src_b),
        .i_immediate(imm), .i_target_index(target), .o_valid(rsp_valid),
        .i_ready(rsp_ready), .o_next_pc(next_pc), .o_wrote_register(wrote_register),
        .o_written_index(written_index), .o_written_value(written_value), .o_fault(fault)
    );

    mse_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_req_valid(req_valid), .i_req_ready(req_ready),
        .i_mode(mode), .i_dest_reg(dest_reg), .i_src_reg_a(src_a), .i_src_reg_b(src_b),
        .i_immediate(imm), .i_target_index(target), .i_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready), .i_next_pc(next_pc), .i_wrote_register(wrote_register),
        .i_written_index(written_index), .i_written_value(written_value), .i_fault(fault),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("mips_subset_execute verification failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (hold_off)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= calm || ($urandom_range(99) >= 33);
    end

    task automatic send(logic [3:0] m, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                        logic [15:0] im, logic [9:0] tg);
        if (!calm) begin
            while ($urandom_range(99) < 33) begin
                req_valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_valid <= 1'b1;
        mode      <= m;
        dest_reg  <= rd;
        src_a     <= ra;
        src_b     <= rb;
        imm       <= im;
        target    <= tg;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [3:0]  m;
        logic [4:0]  ra;
        logic [15:0] im;
        m  = ($urandom_range(99) < 5) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
        ra = 5'($urandom_range(31));
        im = 16'($urandom);
        if ((m == mse_pkg::OP_LW || m == mse_pkg::OP_SW) && $urandom_range(99) < 75) begin
            ra = mse_pkg::SP_REG;
            im = 16'($signed($urandom_range(200)) - 100);
        end
        if (m == mse_pkg::OP_ADDI && $urandom_range(99) < 30) im = 16'($urandom_range(40));
        send(m, 5'($urandom_range(31)), ra, 5'($urandom_range(31)), im, 10'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send(mse_pkg::OP_DIV, 5'd1, 5'd2, 5'd3, 16'd0, 10'd0);
        send(mse_pkg::OP_ADDI, 5'd1, 5'd0, 5'd0, 16'h7fff, 10'd0);
        send(mse_pkg::OP_SUBI, 5'd2, 5'd0, 5'd0, 16'h8000, 10'd0);
        send(mse_pkg::OP_MUL, 5'd3, 5'd1, 5'd2, 16'd0, 10'd0);
        send(mse_pkg::OP_ADDI, 5'd4, 5'd0, 5'd0, 16'hffff, 10'd0);
        send(mse_pkg::OP_MUL, 5'd5, 5'd2, 5'd2, 16'd0, 10'd0);
        send(mse_pkg::OP_ADD, 5'd5, 5'd5, 5'd5, 16'd0, 10'd0);
        send(mse_pkg::OP_SUBI, 5'd5, 5'd4, 5'd0, 16'h7fff, 10'd0);
        send(mse_pkg::OP_MUL, 5'd5, 5'd5, 5'd2, 16'd0, 10'd0);
        send(mse_pkg::OP_ADD, 5'd6, 5'd3, 5'd3, 16'd0, 10'd0);
        send(mse_pkg::OP_SUB, 5'd6, 5'd0, 5'd3, 16'd0, 10'd0);
        send(mse_pkg::OP_SUBI, 5'd7, 5'd0, 5'd0, 16'd0, 10'd0);
        send(mse_pkg::OP_SUB, 5'd7, 5'd0, 5'd6, 16'd0, 10'd0);
        send(mse_pkg::OP_SUB, 5'd8, 5'd7, 5'd6, 16'd0, 10'd0);
        send(mse_pkg::OP_DIV, 5'd9, 5'd6, 5'd4, 16'd0, 10'd0);
        send(mse_pkg::OP_DIV, 5'd9, 5'd3, 5'd4, 16'd0, 10'd0);
        send(mse_pkg::OP_SW, 5'd3, mse_pkg::SP_REG, 5'd0, 16'h005c, 10'd0);
        send(mse_pkg::OP_LW, 5'd10, mse_pkg::SP_REG, 5'd0, 16'h005c, 10'd0);
        send(mse_pkg::OP_LW, 5'd10, mse_pkg::SP_REG, 5'd0, 16'h0060, 10'd0);
        send(mse_pkg::OP_LW, 5'd10, mse_pkg::SP_REG, 5'd0, 16'h8000, 10'd0);
        send(mse_pkg::OP_SW, 5'd3, 5'd1, 5'd0, 16'd0, 10'd0);
        send(mse_pkg::OP_BEQ, 5'd0, 5'd0, 5'd31, 16'd0, 10'h3ff);
        send(mse_pkg::OP_BEQ, 5'd0, 5'd0, 5'd1, 16'd0, 10'd5);
        send(mse_pkg::OP_J, 5'd0, 5'd0, 5'd0, 16'd0, 10'd0);
        send(4'd15, 5'd31, 5'd31, 5'd31, 16'hffff, 10'h3ff);

        for (int i = 0; i < 500; i++) begin
            calm = (i >= 150 && i < 250);
            if (i == 300) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            send_random();
        end
        req_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("mips_subset_execute verification clean");
        else
            $display("mips_subset_execute verification failed");
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/mse_pkg.sv
src/mips_subset_execute.sv
dv/mse_checker.sv
dv/tb_mips_subset_execute.sv
